FILE: src/pgr_pkg.sv
// Shared definitions of the packed glyph row renderer: sizes, codes, the glyph table
// entry layout, state machine types and the control structs between top level and walker.
// Depends on nothing; the walker, the top level and the testbench refer to it by scoped names.
package pgr_pkg;

   localparam int BITMAP_BYTES     = 4096;
   localparam int GLYPH_SLOTS      = 256;
   localparam int MAX_GLYPH_WIDTH  = 32;
   localparam int MAX_GLYPH_HEIGHT = 32;

   localparam int BM_ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
   localparam int SLOT_W    = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Request opcodes.
   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_GLYPH = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CHAR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_CHAR    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_ADVANCE = 2'd2;

   localparam logic [7:0] FIRST_CHAR_RESET   = 8'd32;
   localparam logic [7:0] LAST_CHAR_RESET    = 8'd126;
   localparam logic [7:0] LINE_ADVANCE_RESET = 8'd0;

   typedef struct packed {
      logic [11:0] offset;
      logic [5:0]  width;
      logic [5:0]  height;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [7:0]  advance;
   } pgr_glyph_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_ROW,
      S_WAIT,
      S_EMIT
   } pgr_state_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_READ,
      W_MERGE
   } pgr_walk_state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [BM_ADDR_W-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 glyph_start;
      logic                 row_start;
      logic [BM_ADDR_W-1:0] offset;
      logic [5:0]           width;
   } pgr_walk_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] mask;
   } pgr_walk_stat_type;

endpackage

FILE: src/pgr_channels.sv
// Valid/ready channel interfaces of the packed glyph row renderer: request and response.
// Stand-alone; the field widths follow the block's request and response formats.
interface pgr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [7:0]  char_code;
   logic [15:0] pixel_color;
   logic [11:0] table_index;
   logic [7:0]  table_byte;
   logic [5:0]  glyph_width;
   logic [5:0]  glyph_height;
   logic [7:0]  glyph_dx;
   logic [7:0]  glyph_dy;
   logic [7:0]  glyph_advance;

   modport source (
      output valid, opcode, pos_x, pos_y, char_code, pixel_color, table_index,
             table_byte, glyph_width, glyph_height, glyph_dx, glyph_dy, glyph_advance,
      input  ready
   );
   modport sink (
      input  valid, opcode, pos_x, pos_y, char_code, pixel_color, table_index,
             table_byte, glyph_width, glyph_height, glyph_dx, glyph_dy, glyph_advance,
      output ready
   );
endinterface

interface pgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] row_x;
   logic [15:0] row_y;
   logic [31:0] pixel_mask;
   logic [15:0] row_color;
   logic [7:0]  advance;
   logic        last;

   modport source (
      output valid, row_x, row_y, pixel_mask, row_color, advance, last,
      input  ready
   );
   modport sink (
      input  valid, row_x, row_y, pixel_mask, row_color, advance, last,
      output ready
   );
endinterface

FILE: src/pgr_bitmap_walker.sv
// Bitmap byte store and row gatherer: fetches the bytes of one glyph row and builds its mask.
// Depends on pgr_pkg for sizes, the walker state type and the command/status structs.
module pgr_bitmap_walker (
   input  logic                      clock,
   input  logic                      reset,
   input  pgr_pkg::pgr_walk_cmd_type  cmd,
   output pgr_pkg::pgr_walk_stat_type stat
);

   logic [7:0] bitmap_mem [pgr_pkg::BITMAP_BYTES];

   pgr_pkg::pgr_walk_state_type state_ff, state_in;

   logic [pgr_pkg::BM_ADDR_W-1:0] addr_ff;
   logic [2:0]                    phase_ff;
   logic [5:0]                    remain_ff;
   logic [5:0]                    fill_ff;
   logic [31:0]                   mask_ff;
   logic [7:0]                    rd_data_ff;
   logic                          done_ff;

   logic       rd_en;
   logic       merge_en;
   logic [3:0] avail;
   logic [3:0] take;
   logic [7:0] rev;
   logic [7:0] take_mask;
   logic [7:0] seg;
   logic [31:0] ins;
   logic [3:0] psum;
   logic [5:0] remain_left;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgr_pkg::W_IDLE: begin
            if (cmd.row_start && cmd.width != 6'd0) state_in = pgr_pkg::W_READ;
         end
         pgr_pkg::W_READ: begin
            state_in = pgr_pkg::W_MERGE;
         end
         pgr_pkg::W_MERGE: begin
            state_in = (remain_left == 6'd0) ? pgr_pkg::W_IDLE : pgr_pkg::W_READ;
         end
         default: begin
            state_in = pgr_pkg::W_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_en    = (state_ff == pgr_pkg::W_READ);
      merge_en = (state_ff == pgr_pkg::W_MERGE);
   end

   // Pixels are packed MSB first, so the byte is reversed to put pixel order at bit 0.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rev[k] = rd_data_ff[7-k];
      end
      avail       = 4'd8 - {1'b0, phase_ff};
      take        = (remain_ff < {2'b00, avail}) ? remain_ff[3:0] : avail;
      take_mask   = 8'((9'd1 << take) - 9'd1);
      seg         = (rev >> phase_ff) & take_mask;
      ins         = {24'd0, seg} << fill_ff[4:0];
      psum        = {1'b0, phase_ff} + take;
      remain_left = remain_ff - {2'b00, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgr_pkg::W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (cmd.row_start && cmd.width == 6'd0) ||
                     (merge_en && remain_left == 6'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_start) begin
         addr_ff  <= cmd.offset;
         phase_ff <= 3'd0;
      end
      if (cmd.row_start) begin
         mask_ff   <= 32'd0;
         fill_ff   <= 6'd0;
         remain_ff <= cmd.width;
      end
      if (merge_en) begin
         mask_ff   <= mask_ff | ins;
         fill_ff   <= fill_ff + {2'b00, take};
         remain_ff <= remain_left;
         phase_ff  <= psum[2:0];
         addr_ff   <= addr_ff + pgr_pkg::BM_ADDR_W'(psum[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bitmap_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[addr_ff];
      end
   end

   assign stat.done = done_ff;
   assign stat.mask = mask_ff;

endmodule

FILE: src/packed_glyph_row_renderer.sv
// Top level of the packed glyph row renderer: control sequencer, glyph table and result register.
// Depends on pgr_pkg, the channel interfaces in pgr_channels and pgr_bitmap_walker.
//
// Usage. Transactions arrive on the request channel; a write of a bitmap byte or of a glyph
// table entry gives no response. A draw transaction gives one response per glyph row, the
// final one with last set and the glyph's x advance; a character outside first_char..last_char,
// or a glyph of zero height, gives a single empty response. The user must write the configuration
// registers over the csr port while the block is idle; the block itself does not enforce this.
//
// Timing. A draw is taken only when the sequencer is idle. The glyph table is read in the
// cycle of acceptance; the setup state follows, then for each row the row, wait and emit
// states. While the sequencer waits, the bitmap walker reads the bytes the row touches (at
// most five): the bitmap memory is read one byte at a time and each byte is merged in the
// cycle after its read. A draw out of range goes from acceptance straight to the emit
// state, and a glyph of zero height from the setup state to the emit state.
//
// Reset clears the sequencer, the response register and the configuration registers to
// their defaults; the bitmap store and glyph table hold nothing defined until written.
// A stalled response receiver holds the result in the output register; the sequencer waits
// with the next row until that register is free, and accepts the next request once the
// final row of a draw has moved into it.
module packed_glyph_row_renderer (
   input  logic                               clock,
   input  logic                               reset,
   pgr_req_if.sink                            req_if,
   pgr_rsp_if.source                          rsp_if,
   input  logic                               csr_wr_en,
   input  logic [pgr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pgr_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   // Configuration registers.
   logic [7:0] first_char_ff;
   logic [7:0] last_char_ff;
   logic [7:0] line_advance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_char_ff   <= pgr_pkg::FIRST_CHAR_RESET;
         last_char_ff    <= pgr_pkg::LAST_CHAR_RESET;
         line_advance_ff <= pgr_pkg::LINE_ADVANCE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            pgr_pkg::CSR_FIRST_CHAR:   first_char_ff   <= csr_wr_data;
            pgr_pkg::CSR_LAST_CHAR:    last_char_ff    <= csr_wr_data;
            pgr_pkg::CSR_LINE_ADVANCE: line_advance_ff <= csr_wr_data;
            default: begin
               // Indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   // Request decode.
   pgr_pkg::pgr_state_type state_ff, state_in;

   logic       req_take;
   logic       draw_take;
   logic       out_of_range;
   logic [7:0] slot;
   logic       slot_ok;

   assign req_take     = req_if.valid && req_if.ready;
   assign draw_take    = req_take && (req_if.opcode == pgr_pkg::OP_DRAW);
   assign out_of_range = (req_if.char_code < first_char_ff) ||
                         (req_if.char_code > last_char_ff);
   assign slot         = req_if.char_code - first_char_ff;
   assign slot_ok      = ({1'b0, slot} < 9'(pgr_pkg::GLYPH_SLOTS));

   // Glyph table: written by entry transactions, read once when a draw is accepted.
   pgr_pkg::pgr_glyph_type glyph_mem [pgr_pkg::GLYPH_SLOTS];
   pgr_pkg::pgr_glyph_type glyph_rd_ff;
   pgr_pkg::pgr_glyph_type glyph_wr;
   logic                   glyph_wr_en;

   always_comb begin
      glyph_wr.offset  = req_if.table_index;
      glyph_wr.width   = req_if.glyph_width;
      glyph_wr.height  = req_if.glyph_height;
      glyph_wr.dx      = req_if.glyph_dx;
      glyph_wr.dy      = req_if.glyph_dy;
      glyph_wr.advance = req_if.glyph_advance;
   end

   assign glyph_wr_en = req_take && (req_if.opcode == pgr_pkg::OP_GLYPH) &&
                        ({1'b0, req_if.char_code} < 9'(pgr_pkg::GLYPH_SLOTS));

   always_ff @(posedge clock) begin
      if (glyph_wr_en) begin
         glyph_mem[req_if.char_code[pgr_pkg::SLOT_W-1:0]] <= glyph_wr;
      end
      if (draw_take) begin
         glyph_rd_ff <= glyph_mem[slot[pgr_pkg::SLOT_W-1:0]];
      end
   end

   // Draw context held for the duration of one draw.
   logic [15:0] pen_x_ff;
   logic [15:0] pen_y_ff;
   logic [15:0] color_ff;
   logic        slot_ok_ff;
   logic [5:0]  width_ff;
   logic [15:0] x_ff;
   logic [15:0] y_ff;
   logic [31:0] mask_ff;
   logic [7:0]  adv_ff;
   logic [5:0]  rows_left_ff;

   // A slot past the end of the table reads as an all-zero glyph.
   pgr_pkg::pgr_glyph_type glyph_eff;
   logic [5:0]             width_clamped;
   logic [5:0]             height_clamped;
   logic                   row_last;

   always_comb begin
      glyph_eff      = slot_ok_ff ? glyph_rd_ff : '0;
      width_clamped  = (glyph_eff.width > 6'(pgr_pkg::MAX_GLYPH_WIDTH)) ?
                       6'(pgr_pkg::MAX_GLYPH_WIDTH) : glyph_eff.width;
      height_clamped = (glyph_eff.height > 6'(pgr_pkg::MAX_GLYPH_HEIGHT)) ?
                       6'(pgr_pkg::MAX_GLYPH_HEIGHT) : glyph_eff.height;
   end

   assign row_last = (rows_left_ff == 6'd1);

   // Response register.
   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff;
   logic [15:0] rsp_y_ff;
   logic [31:0] rsp_mask_ff;
   logic [15:0] rsp_color_ff;
   logic [7:0]  rsp_adv_ff;
   logic        rsp_last_ff;
   logic        out_load;

   // Row walker over the bitmap store.
   pgr_pkg::pgr_walk_cmd_type  walk_cmd;
   pgr_pkg::pgr_walk_stat_type walk_stat;

   pgr_bitmap_walker u_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (walk_cmd),
      .stat  (walk_stat)
   );

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgr_pkg::S_IDLE: begin
            if (draw_take) begin
               state_in = out_of_range ? pgr_pkg::S_EMIT : pgr_pkg::S_SETUP;
            end
         end
         pgr_pkg::S_SETUP: begin
            state_in = (height_clamped == 6'd0) ? pgr_pkg::S_EMIT : pgr_pkg::S_ROW;
         end
         pgr_pkg::S_ROW: begin
            state_in = pgr_pkg::S_WAIT;
         end
         pgr_pkg::S_WAIT: begin
            if (walk_stat.done) state_in = pgr_pkg::S_EMIT;
         end
         pgr_pkg::S_EMIT: begin
            if (out_load) state_in = row_last ? pgr_pkg::S_IDLE : pgr_pkg::S_ROW;
         end
         default: begin
            state_in = pgr_pkg::S_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_if.ready         = (state_ff == pgr_pkg::S_IDLE);
      out_load             = (state_ff == pgr_pkg::S_EMIT) && (!rsp_valid_ff || rsp_if.ready);
      walk_cmd.wr_en       = req_take && (req_if.opcode == pgr_pkg::OP_BYTE);
      walk_cmd.wr_addr     = pgr_pkg::BM_ADDR_W'(req_if.table_index);
      walk_cmd.wr_data     = req_if.table_byte;
      walk_cmd.glyph_start = (state_ff == pgr_pkg::S_SETUP);
      walk_cmd.row_start   = (state_ff == pgr_pkg::S_ROW);
      walk_cmd.offset      = pgr_pkg::BM_ADDR_W'(glyph_eff.offset);
      walk_cmd.width       = width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Draw datapath. The row y counts up from the glyph's top after every response.
   always_ff @(posedge clock) begin
      if (draw_take) begin
         pen_x_ff   <= req_if.pos_x;
         pen_y_ff   <= req_if.pos_y;
         color_ff   <= req_if.pixel_color;
         slot_ok_ff <= slot_ok;
         if (out_of_range) begin
            x_ff         <= req_if.pos_x;
            y_ff         <= req_if.pos_y;
            mask_ff      <= 32'd0;
            adv_ff       <= 8'd0;
            rows_left_ff <= 6'd1;
         end
      end
      if (state_ff == pgr_pkg::S_SETUP) begin
         width_ff     <= width_clamped;
         x_ff         <= pen_x_ff + {{8{glyph_eff.dx[7]}}, glyph_eff.dx};
         y_ff         <= pen_y_ff + {{8{glyph_eff.dy[7]}}, glyph_eff.dy} +
                         {8'd0, line_advance_ff};
         adv_ff       <= glyph_eff.advance;
         mask_ff      <= 32'd0;
         rows_left_ff <= (height_clamped == 6'd0) ? 6'd1 : height_clamped;
      end
      if (state_ff == pgr_pkg::S_WAIT && walk_stat.done) begin
         mask_ff <= walk_stat.mask;
      end
      if (out_load) begin
         y_ff         <= y_ff + 16'd1;
         rows_left_ff <= rows_left_ff - 6'd1;
      end
   end

   // The response register frees as soon as the receiver takes its transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_x_ff     <= x_ff;
         rsp_y_ff     <= y_ff;
         rsp_mask_ff  <= mask_ff;
         rsp_color_ff <= color_ff;
         rsp_adv_ff   <= row_last ? adv_ff : 8'd0;
         rsp_last_ff  <= row_last;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.row_x      = rsp_x_ff;
   assign rsp_if.row_y      = rsp_y_ff;
   assign rsp_if.pixel_mask = rsp_mask_ff;
   assign rsp_if.row_color  = rsp_color_ff;
   assign rsp_if.advance    = rsp_adv_ff;
   assign rsp_if.last       = rsp_last_ff;

endmodule

FILE: test/tb.sv
// Self-checking testbench for packed_glyph_row_renderer: fills the bitmap store and glyph table,
// draws characters and checks every glyph row against a scoreboard with its own row predictor.
// Depends on pgr_pkg, the channel interfaces in pgr_channels and the block itself.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Opcode 3 has no meaning; the block must swallow it without a response.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // The receiver's long hold-off, counted in its own process.
   localparam int HOLDOFF_CYCLES = 1000;
   // Cycles without any transaction before the run is declared hung. The longest
   // legal quiet stretch is the hold-off plus one row.
   localparam int WATCHDOG_LIMIT = 6000;
   // A write transaction may still be settling after the last expected row.
   localparam int SETTLE_CYCLES = 32;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  char_code;
      logic [15:0] pixel_color;
      logic [11:0] table_index;
      logic [7:0]  table_byte;
      logic [5:0]  glyph_width;
      logic [5:0]  glyph_height;
      logic [7:0]  glyph_dx;
      logic [7:0]  glyph_dy;
      logic [7:0]  glyph_advance;
   } glyph_req_type;

   typedef struct packed {
      logic [15:0] row_x;
      logic [15:0] row_y;
      logic [31:0] pixel_mask;
      logic [15:0] row_color;
      logic [7:0]  advance;
      logic        last;
   } row_result_type;

   // Holds a private copy of the bitmap store, the glyph table and the configuration,
   // predicts the rows of each draw and checks the rows that come out.
   class glyph_row_scoreboard;
      logic [7:0]             bitmap[pgr_pkg::BITMAP_BYTES];
      bit                     byte_written[pgr_pkg::BITMAP_BYTES];
      pgr_pkg::pgr_glyph_type glyphs[pgr_pkg::GLYPH_SLOTS];
      bit                     glyph_written[pgr_pkg::GLYPH_SLOTS];
      logic [7:0]             first_code = pgr_pkg::FIRST_CHAR_RESET;
      logic [7:0]             last_code  = pgr_pkg::LAST_CHAR_RESET;
      logic [7:0]             row_offset = pgr_pkg::LINE_ADVANCE_RESET;
      row_result_type         expected_rows[$];
      int                     errors = 0;

      static function int clamp_dim(logic [5:0] v, int limit);
         return (v > limit) ? limit : int'(v);
      endfunction

      // Bitmap bytes a glyph touches; rows are packed with no padding.
      static function int glyph_byte_count(logic [5:0] w, logic [5:0] h);
         return (clamp_dim(w, pgr_pkg::MAX_GLYPH_WIDTH) *
                 clamp_dim(h, pgr_pkg::MAX_GLYPH_HEIGHT) + 7) / 8;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      function bit out_of_range(logic [7:0] code);
         return (code < first_code) || (code > last_code);
      endfunction

      // True when a draw of this character reads only defined table entries and bytes.
      function bit can_draw(logic [7:0] code);
         pgr_pkg::pgr_glyph_type g;
         int                     n;
         if (out_of_range(code)) return 1'b1;
         if (!glyph_written[code - first_code]) return 1'b0;
         g = glyphs[code - first_code];
         n = glyph_byte_count(g.width, g.height);
         for (int k = 0; k < n; k++)
            if (!byte_written[(int'(g.offset) + k) % pgr_pkg::BITMAP_BYTES]) return 1'b0;
         return 1'b1;
      endfunction

      function void render_rows(glyph_req_type r);
         pgr_pkg::pgr_glyph_type g;
         int                     wc, hc, bitpos, addr;
         logic [15:0]            x0, y0;
         logic [31:0]            mask;
         if (out_of_range(r.char_code)) begin
            expected_rows.push_back('{r.pos_x, r.pos_y, 32'h0, r.pixel_color, 8'h00, 1'b1});
            return;
         end
         g  = glyphs[r.char_code - first_code];
         wc = clamp_dim(g.width, pgr_pkg::MAX_GLYPH_WIDTH);
         hc = clamp_dim(g.height, pgr_pkg::MAX_GLYPH_HEIGHT);
         x0 = r.pos_x + {{8{g.dx[7]}}, g.dx};
         y0 = r.pos_y + {{8{g.dy[7]}}, g.dy} + {8'h00, row_offset};
         if (hc == 0) begin
            expected_rows.push_back('{x0, y0, 32'h0, r.pixel_color, g.advance, 1'b1});
            return;
         end
         // The bit index runs on across row ends; bytes are read MSB first.
         bitpos = 0;
         for (int row = 0; row < hc; row++) begin
            mask = '0;
            for (int col = 0; col < wc; col++) begin
               addr = (int'(g.offset) + bitpos / 8) % pgr_pkg::BITMAP_BYTES;
               if (bitmap[addr][7 - bitpos % 8]) mask[col] = 1'b1;
               bitpos++;
            end
            expected_rows.push_back('{x0, y0 + 16'(row), mask, r.pixel_color,
                                      (row == hc - 1) ? g.advance : 8'h00, row == hc - 1});
         end
      endfunction

      function void note_request(glyph_req_type r);
         case (r.opcode)
            pgr_pkg::OP_BYTE: begin
               bitmap[r.table_index % pgr_pkg::BITMAP_BYTES]       = r.table_byte;
               byte_written[r.table_index % pgr_pkg::BITMAP_BYTES] = 1'b1;
            end
            pgr_pkg::OP_GLYPH: begin
               glyphs[r.char_code] = '{r.table_index, r.glyph_width, r.glyph_height,
                                       r.glyph_dx, r.glyph_dy, r.glyph_advance};
               glyph_written[r.char_code] = 1'b1;
            end
            pgr_pkg::OP_DRAW: render_rows(r);
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("row mismatch: %s", what);
      endtask

      task check_row(row_result_type got);
         row_result_type want;
         string          bad;
         if (expected_rows.size() == 0) begin
            report($sformatf("unexpected row x=%h y=%h mask=%h color=%h adv=%h last=%b",
                             got.row_x, got.row_y, got.pixel_mask, got.row_color,
                             got.advance, got.last));
            return;
         end
         want = expected_rows.pop_front();
         bad  = "";
         if (got.row_x !== want.row_x) bad = {bad, " row_x"};
         if (got.row_y !== want.row_y) bad = {bad, " row_y"};
         if (got.pixel_mask !== want.pixel_mask) bad = {bad, " pixel_mask"};
         if (got.row_color !== want.row_color) bad = {bad, " row_color"};
         if (got.advance !== want.advance) bad = {bad, " advance"};
         if (got.last !== want.last) bad = {bad, " last"};
         if (bad != "")
            report($sformatf("%s: got %h/%h/%h/%h/%h/%b, expected %h/%h/%h/%h/%h/%b", bad,
                             got.row_x, got.row_y, got.pixel_mask, got.row_color,
                             got.advance, got.last, want.row_x, want.row_y,
                             want.pixel_mask, want.row_color, want.advance, want.last));
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_wr_en;
   logic [pgr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pgr_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   pgr_req_if req_if();
   pgr_rsp_if rsp_if();

   glyph_row_scoreboard sb = new;

   // Shared between the stimulus and the receiver: the request for the long hold-off and
   // the quiet last phase in which neither side idles; the gap switch is the sender's own.
   bit holdoff_requested = 1'b0;
   bit quiet_tail        = 1'b0;
   bit sender_gaps       = 1'b0;
   int items_sent        = 0;
   int stalled_cycles    = 0;

   packed_glyph_row_renderer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every field starts random so that each bit of each field toggles, whatever the opcode.
   function automatic glyph_req_type random_req();
      logic [127:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom};
      return bits[$bits(glyph_req_type)-1:0];
   endfunction

   // Offers one transaction and returns at the edge where it is taken. The valid stays
   // high afterwards; the caller either offers the next transaction in the same step or
   // lowers valid. A random idle burst may come first.
   task automatic send_req(input glyph_req_type r);
      if (sender_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.opcode        <= r.opcode;
      req_if.pos_x         <= r.pos_x;
      req_if.pos_y         <= r.pos_y;
      req_if.char_code     <= r.char_code;
      req_if.pixel_color   <= r.pixel_color;
      req_if.table_index   <= r.table_index;
      req_if.table_byte    <= r.table_byte;
      req_if.glyph_width   <= r.glyph_width;
      req_if.glyph_height  <= r.glyph_height;
      req_if.glyph_dx      <= r.glyph_dx;
      req_if.glyph_dy      <= r.glyph_dy;
      req_if.glyph_advance <= r.glyph_advance;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(r);
      if (r.opcode != OP_UNUSED) items_sent++;
   endtask

   // Writes the table entry of a slot and then every bitmap byte the glyph reads,
   // with random contents, so that a draw of it never touches undefined storage.
   task automatic define_glyph(input logic [7:0] slot, input logic [11:0] offset,
                               input logic [5:0] w, input logic [5:0] h,
                               input logic [7:0] dx, input logic [7:0] dy,
                               input logic [7:0] adv);
      glyph_req_type r;
      int            n;
      r               = random_req();
      r.opcode        = pgr_pkg::OP_GLYPH;
      r.char_code     = slot;
      r.table_index   = offset;
      r.glyph_width   = w;
      r.glyph_height  = h;
      r.glyph_dx      = dx;
      r.glyph_dy      = dy;
      r.glyph_advance = adv;
      send_req(r);
      n = glyph_row_scoreboard::glyph_byte_count(w, h);
      for (int k = 0; k < n; k++) begin
         r             = random_req();
         r.opcode      = pgr_pkg::OP_BYTE;
         r.table_index = offset + 12'(k);
         send_req(r);
      end
   endtask

   task automatic draw_char(input logic [7:0] code, input logic [15:0] x,
                            input logic [15:0] y);
      glyph_req_type r;
      r           = random_req();
      r.opcode    = pgr_pkg::OP_DRAW;
      r.char_code = code;
      r.pos_x     = x;
      r.pos_y     = y;
      send_req(r);
   endtask

   // The sender stops and waits until every predicted row has arrived, then lets the
   // block settle, so that configuration writes land on an idle block.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Response side: checks each accepted row and drives ready. Ready comes in random
   // stall bursts whose density is drawn anew for each segment (sometimes none at all), plus
   // one long hold-off on request; in the quiet last phase it stays high.
   initial begin : response_side
      int             stall_left;
      int             segment_left;
      int             stall_odds;
      row_result_type got;
      stall_left   = 0;
      segment_left = 0;
      stall_odds   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.row_x, rsp_if.row_y, rsp_if.pixel_mask, rsp_if.row_color,
                   rsp_if.advance, rsp_if.last};
            sb.check_row(got);
         end
         if (segment_left == 0) begin
            segment_left = 64;
            case ($urandom_range(0, 2))
               0: stall_odds = 0;
               1: stall_odds = 4;
               default: stall_odds = 12;
            endcase
         end
         segment_left--;
         if (stall_left > 0) begin
            stall_left--;
         end else if (holdoff_requested) begin
            holdoff_requested = 1'b0;
            stall_left        = HOLDOFF_CYCLES;
         end else if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left = $urandom_range(1, 15);
         end
         rsp_if.ready <= !reset && stall_left == 0;
      end
   end

   // Any cycle with a transaction on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("** packed_glyph_row_renderer: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int            target;
      int            pick;
      logic [7:0]    code;
      logic [7:0]    slot;
      logic [7:0]    cfg_first;
      logic [7:0]    cfg_last;
      logic [7:0]    cfg_advance;
      logic [5:0]    w;
      logic [5:0]    h;
      glyph_req_type r;

      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.opcode <= pgr_pkg::OP_DRAW;
      req_if.pos_x <= '0;
      req_if.pos_y <= '0;
      req_if.char_code <= '0;
      req_if.pixel_color <= '0;
      req_if.table_index <= '0;
      req_if.table_byte <= '0;
      req_if.glyph_width <= '0;
      req_if.glyph_height <= '0;
      req_if.glyph_dx <= '0;
      req_if.glyph_dy <= '0;
      req_if.glyph_advance <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset configuration (characters 32 to 126).
      // Characters on both sides of the range give a single empty row.
      draw_char(8'd0, 16'h8000, 16'h7fff);
      draw_char(8'd255, 16'h7fff, 16'h8000);
      // A glyph of zero height gives one empty row that still carries the advance.
      define_glyph(8'd0, 12'd10, 6'd7, 6'd0, 8'd3, 8'hfd, 8'd9);
      draw_char(pgr_pkg::FIRST_CHAR_RESET, 16'h0000, 16'h0000);
      // Zero width: one empty row per glyph row.
      define_glyph(8'd1, 12'd20, 6'd0, 6'd5, 8'd0, 8'd0, 8'd4);
      draw_char(pgr_pkg::FIRST_CHAR_RESET + 8'd1, 16'hffff, 16'hffff);
      // Oversize in both directions, bytes wrapping past the end of the store,
      // the most negative dx and most positive dy, coordinates wrapping at 16 bits.
      define_glyph(8'd2, 12'd4090, 6'd63, 6'd63, 8'h80, 8'h7f, 8'hff);
      draw_char(pgr_pkg::FIRST_CHAR_RESET + 8'd2, 16'h7fff, 16'h7fff);
      // Full-width single row starting at the last byte of the store.
      define_glyph(8'd3, 12'd4095, 6'd32, 6'd1, 8'h7f, 8'h80, 8'h00);
      draw_char(pgr_pkg::FIRST_CHAR_RESET + 8'd3, 16'h8000, 16'h8000);
      // Width above the maximum with a short height.
      define_glyph(8'd4, 12'd200, 6'd40, 6'd3, 8'hff, 8'h01, 8'd12);
      draw_char(pgr_pkg::FIRST_CHAR_RESET + 8'd4, 16'h0001, 16'hfffe);
      // The last character of the range, with a height that clamps.
      define_glyph(pgr_pkg::LAST_CHAR_RESET - pgr_pkg::FIRST_CHAR_RESET, 12'd0, 6'd5, 6'd40,
                   8'd2, 8'd1, 8'd6);
      draw_char(pgr_pkg::LAST_CHAR_RESET, 16'h1234, 16'h4321);
      draw_char(pgr_pkg::FIRST_CHAR_RESET - 8'd1, 16'h0000, 16'hffff);
      draw_char(pgr_pkg::LAST_CHAR_RESET + 8'd1, 16'hffff, 16'h0000);
      // The unused opcode is swallowed.
      r        = random_req();
      r.opcode = OP_UNUSED;
      send_req(r);

      // Random phases, each under its own configuration.
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: begin cfg_first = 8'd0;   cfg_last = 8'd255; cfg_advance = 8'd255; end
            1: begin cfg_first = 8'd255; cfg_last = 8'd0;   cfg_advance = 8'd0;   end
            2: begin
               cfg_first   = 8'($urandom_range(0, 100));
               cfg_last    = 8'($urandom_range(cfg_first, 255));
               cfg_advance = 8'($urandom);
            end
            3: begin cfg_first = 8'd255; cfg_last = 8'd255; cfg_advance = 8'd1; end
            4: begin cfg_first = 8'($urandom); cfg_last = 8'($urandom); cfg_advance = 8'($urandom); end
            default: begin
               cfg_first   = pgr_pkg::FIRST_CHAR_RESET;
               cfg_last    = pgr_pkg::LAST_CHAR_RESET;
               cfg_advance = pgr_pkg::LINE_ADVANCE_RESET;
               quiet_tail  = 1'b1;
            end
         endcase
         csr_wr_en   <= 1'b1;
         csr_index   <= pgr_pkg::CSR_FIRST_CHAR;
         csr_wr_data <= cfg_first;
         @(posedge clock);
         csr_index   <= pgr_pkg::CSR_LAST_CHAR;
         csr_wr_data <= cfg_last;
         @(posedge clock);
         csr_index   <= pgr_pkg::CSR_LINE_ADVANCE;
         csr_wr_data <= cfg_advance;
         @(posedge clock);
         csr_wr_en     <= 1'b0;
         sb.first_code = cfg_first;
         sb.last_code  = cfg_last;
         sb.row_offset = cfg_advance;

         // Back pressure: the receiver holds off for a long stretch while draws keep
         // coming, so the output register and then the request side fill up.
         if (phase == 2) begin
            define_glyph(8'd0, 12'($urandom), 6'($urandom_range(1, 12)),
                         6'($urandom_range(1, 8)), 8'($urandom), 8'($urandom), 8'($urandom));
            holdoff_requested = 1'b1;
            sender_gaps       = 1'b0;
            repeat (8) draw_char(cfg_first, 16'($urandom), 16'($urandom));
            wait_idle();
         end

         target = items_sent + ((phase == 1) ? 20 : (phase == 3) ? 40 : 60);
         while (items_sent < target) begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            pick        = $urandom_range(0, 19);
            if (pick <= 10) begin
               // Well-formed sequence: define a glyph of a character, then draw it.
               if (sb.first_code <= sb.last_code)
                  code = 8'($urandom_range(sb.first_code, sb.last_code));
               else
                  code = 8'($urandom);
               slot = code - sb.first_code;
               // Mostly small glyphs; now and then any size the fields allow.
               if ($urandom_range(0, 15) == 0) begin
                  w = 6'($urandom);
                  h = 6'($urandom);
               end else begin
                  w = 6'($urandom_range(0, 12));
                  h = 6'($urandom_range(0, 10));
               end
               define_glyph(slot, 12'($urandom), w, h, 8'($urandom), 8'($urandom),
                            8'($urandom));
               repeat ($urandom_range(1, 3)) draw_char(code, 16'($urandom), 16'($urandom));
            end else if (pick <= 13) begin
               // Redraw of whatever the table holds, if it is fully defined.
               if (sb.first_code <= sb.last_code)
                  code = 8'($urandom_range(sb.first_code, sb.last_code));
               else
                  code = 8'($urandom);
               if (sb.can_draw(code)) draw_char(code, 16'($urandom), 16'($urandom));
            end else if (pick <= 15) begin
               // Character outside the configured range, where the range leaves one.
               if (sb.first_code > 0)
                  code = 8'($urandom_range(0, int'(sb.first_code) - 1));
               else if (sb.last_code < 8'd255)
                  code = 8'($urandom_range(int'(sb.last_code) + 1, 255));
               else
                  code = 8'($urandom);
               if (sb.can_draw(code)) draw_char(code, 16'($urandom), 16'($urandom));
            end else if (pick <= 17) begin
               r        = random_req();
               r.opcode = pgr_pkg::OP_BYTE;
               send_req(r);
            end else if (pick == 18) begin
               // A stray entry; the scoreboard keeps it from being drawn while its
               // bytes are undefined.
               r        = random_req();
               r.opcode = pgr_pkg::OP_GLYPH;
               send_req(r);
            end else begin
               r        = random_req();
               r.opcode = OP_UNUSED;
               send_req(r);
            end
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** packed_glyph_row_renderer: PASSED **");
      else
         $display("** packed_glyph_row_renderer: FAILED **");
      $finish;
   end
endmodule

FILE: files.f
src/pgr_pkg.sv
src/pgr_channels.sv
src/pgr_bitmap_walker.sv
src/packed_glyph_row_renderer.sv
test/tb.sv
